// ===== rtl/wfmw_pkg.sv =====
// shared types and constants for the wall follower maze walk
package wfmw_pkg;

  localparam int DEFAULT_MAX_DIM = 128;

  localparam int CNT_W  = 8;
  localparam int STEP_W = 17;

  localparam logic [CNT_W-1:0] COUNT_RESET = 8'd1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_START = 1'b1;

  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_COL_COUNT = 1'b1;

  typedef logic [1:0] heading_t;

  localparam heading_t HEAD_POS_ROW = 2'd0;
  localparam heading_t HEAD_NEG_COL = 2'd1;
  localparam heading_t HEAD_NEG_ROW = 2'd2;
  localparam heading_t HEAD_POS_COL = 2'd3;

  localparam heading_t TURN_RIGHT  = 2'd1;
  localparam heading_t TURN_AROUND = 2'd2;
  localparam heading_t TURN_LEFT   = 2'd3;

  localparam logic [1:0] TRY_FIRST = 2'd0;
  localparam logic [1:0] TRY_AHEAD = 2'd1;
  localparam logic [1:0] TRY_LAST  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START_PROBE,
    ST_START_CHECK,
    ST_PROBE,
    ST_EVAL,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/wfmw_ram.sv =====
// generic single write port ram with registered read
module wfmw_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/wfmw_probe.sv =====
// neighbor cell unit: bounds check and grid address toward one heading
module wfmw_probe #(
  parameter int MAX_DIM = wfmw_pkg::DEFAULT_MAX_DIM,
  parameter int CW      = $clog2(MAX_DIM + 1),
  parameter int IW      = $clog2(MAX_DIM)
) (
  input  logic [CW-1:0]            row,
  input  logic [CW-1:0]            col,
  input  wfmw_pkg::heading_t       dir,
  input  logic [wfmw_pkg::CNT_W-1:0] row_count,
  input  logic [wfmw_pkg::CNT_W-1:0] col_count,
  output logic                     in_bounds,
  output logic [2*IW-1:0]          addr
);

  import wfmw_pkg::*;

  localparam int XW = (CW + 1 > CNT_W) ? CW + 1 : CNT_W;

  logic [XW-1:0] nr;
  logic [XW-1:0] nc;
  logic [XW-1:0] rm1;
  logic [XW-1:0] cm1;
  logic          row_ok;
  logic          col_ok;

  always_comb begin
    nr = XW'(row);
    nc = XW'(col);
    case (dir)
      HEAD_POS_ROW: nr = XW'(row) + XW'(1);
      HEAD_NEG_COL: nc = XW'(col) - XW'(1);
      HEAD_NEG_ROW: nr = XW'(row) - XW'(1);
      HEAD_POS_COL: nc = XW'(col) + XW'(1);
      default: begin
        nr = XW'(row);
        nc = XW'(col);
      end
    endcase
  end

  // wrap below zero lands above MAX_DIM and reads closed
  assign row_ok = (nr != '0) && (nr <= XW'(row_count)) && (nr <= XW'(MAX_DIM));
  assign col_ok = (nc != '0) && (nc <= XW'(col_count)) && (nc <= XW'(MAX_DIM));
  assign in_bounds = row_ok && col_ok;

  assign rm1  = nr - XW'(1);
  assign cm1  = nc - XW'(1);
  assign addr = {rm1[IW-1:0], cm1[IW-1:0]};

endmodule

// ===== rtl/wall_follower_maze_walk.sv =====
// top level of the wall follower maze walk
//
// in channel: one item per handshake. in_tuser = 0 loads one grid cell
// (tdata: cell_row, cell_col, cell_open), in_tuser = 1 starts a walk.
// loads are taken one per cycle while idle and give no result.
// a start runs a walk from cell (1,1) facing +row, first by the left-hand
// rule, then, if the goal (row_count, col_count) was not reached, by the
// right-hand rule, each attempt limited to 2*row_count*col_count steps.
// exactly one result item follows on the out channel: path_found.
// each probed neighbor is read from the grid ram in ST_PROBE and judged in
// ST_EVAL (one registered grid ram read); a step probes one to three neighbors.
// the single ram read port and the shared neighbor unit serialize the probes.
// in_tready is low from a start until its result sits in the out register.
// the out register holds one result; a receiver stall holds a finished walk
// until it is free, and while a result waits there loads are still taken.
// cfg port: cfg_we with cfg_index 0 = row_count, 1 = col_count, only while
// idle. reset sets both counts to 1 and leaves grid contents undefined:
// every cell that a walk can touch must be loaded first.
module wall_follower_maze_walk #(
  parameter int MAX_DIM = wfmw_pkg::DEFAULT_MAX_DIM
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // cell_row[7:0], cell_col[15:8], cell_open[16], zero pad
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // path_found[0], zero pad
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  import wfmw_pkg::*;

  localparam int CW    = $clog2(MAX_DIM + 1);
  localparam int IW    = $clog2(MAX_DIM);
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 1 << AW;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   row_count_r, col_count_r;
  logic [CW-1:0]      row_r, row_nxt;
  logic [CW-1:0]      col_r, col_nxt;
  heading_t           head_r, head_nxt;
  logic [1:0]         try_r, try_nxt;
  logic               rule_r, rule_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [STEP_W-1:0]  limit_r, limit_nxt;
  logic               found_r, found_nxt;
  logic               inb_r;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic               out_found_r, out_found_nxt;

  logic [7:0]         in_row, in_col;
  logic               in_open;
  logic               in_fire;
  logic               load_ok;
  logic [7:0]         in_row_m1, in_col_m1;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic               ram_rdata;

  heading_t           side_first, side_last, cand_dir, probe_dir, move_dir;
  logic               probe_inb;
  logic               cell_open;
  logic               take_step;
  logic [CW-1:0]      mv_row, mv_col;
  logic               at_goal;
  logic [STEP_W-1:0]  step_inc;
  logic               out_free;
  logic [2*CNT_W-1:0] area;

  assign in_row  = in_tdata[7:0];
  assign in_col  = in_tdata[15:8];
  assign in_open = in_tdata[16];

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_found_r};
  assign out_free   = !out_tvalid_r || out_tready;

  // grid load
  assign load_ok   = (in_row != 8'd0) && (in_col != 8'd0) &&
                     ({1'b0, in_row} <= 9'(MAX_DIM)) && ({1'b0, in_col} <= 9'(MAX_DIM));
  assign in_row_m1 = in_row - 8'd1;
  assign in_col_m1 = in_col - 8'd1;
  assign ram_we    = in_fire && (in_tuser == CMD_LOAD) && load_ok;
  assign ram_waddr = {in_row_m1[IW-1:0], in_col_m1[IW-1:0]};

  // candidate heading for the current try
  assign side_first = rule_r ? TURN_RIGHT : TURN_LEFT;
  assign side_last  = rule_r ? TURN_LEFT : TURN_RIGHT;

  always_comb begin
    case (try_r)
      TRY_FIRST: cand_dir = head_r + side_first;
      TRY_AHEAD: cand_dir = head_r;
      TRY_LAST:  cand_dir = head_r + side_last;
      default:   cand_dir = head_r;
    endcase
  end

  assign probe_dir = (state_r == ST_START_PROBE) ? head_r : cand_dir;

  wfmw_probe #(
    .MAX_DIM (MAX_DIM),
    .CW      (CW),
    .IW      (IW)
  ) u_probe (
    .row       (row_r),
    .col       (col_r),
    .dir       (probe_dir),
    .row_count (row_count_r),
    .col_count (col_count_r),
    .in_bounds (probe_inb),
    .addr      (ram_raddr)
  );

  wfmw_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_open),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cell_open = inb_r && ram_rdata;
  assign take_step = cell_open || (try_r == TRY_LAST);
  assign move_dir  = cell_open ? cand_dir : head_r + TURN_AROUND;
  assign step_inc  = step_r + STEP_W'(1);
  assign area      = (2*CNT_W)'(row_count_r) * (2*CNT_W)'(col_count_r);

  always_comb begin
    mv_row = row_r;
    mv_col = col_r;
    case (move_dir)
      HEAD_POS_ROW: mv_row = row_r + CW'(1);
      HEAD_NEG_COL: mv_col = col_r - CW'(1);
      HEAD_NEG_ROW: mv_row = row_r - CW'(1);
      HEAD_POS_COL: mv_col = col_r + CW'(1);
      default: begin
        mv_row = row_r;
        mv_col = col_r;
      end
    endcase
  end

  assign at_goal = ((CNT_W + CW)'(mv_row) == (CNT_W + CW)'(row_count_r)) &&
                   ((CNT_W + CW)'(mv_col) == (CNT_W + CW)'(col_count_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_tuser == CMD_START)) begin
          state_nxt = ST_START_PROBE;
        end
      end
      ST_START_PROBE: state_nxt = ST_START_CHECK;
      ST_START_CHECK: state_nxt = cell_open ? ST_PROBE : ST_DONE;
      ST_PROBE:       state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (take_step && (at_goal || ((step_inc >= limit_r) && rule_r))) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_PROBE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    row_nxt        = row_r;
    col_nxt        = col_r;
    head_nxt       = head_r;
    try_nxt        = try_r;
    rule_nxt       = rule_r;
    step_nxt       = step_r;
    limit_nxt      = limit_r;
    found_nxt      = found_r;
    out_tvalid_nxt = out_tvalid_r;
    out_found_nxt  = out_found_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_tuser == CMD_START)) begin
          // probe the start cell from its -col neighbor
          row_nxt   = CW'(1);
          col_nxt   = '0;
          head_nxt  = HEAD_POS_COL;
          limit_nxt = {area, 1'b0};
        end
      end
      ST_START_CHECK: begin
        found_nxt = 1'b0;
        if (cell_open) begin
          row_nxt  = CW'(1);
          col_nxt  = CW'(1);
          head_nxt = HEAD_POS_ROW;
          try_nxt  = TRY_FIRST;
          rule_nxt = 1'b0;
          step_nxt = '0;
        end
      end
      ST_EVAL: begin
        if (take_step) begin
          try_nxt  = TRY_FIRST;
          step_nxt = step_inc;
          row_nxt  = mv_row;
          col_nxt  = mv_col;
          head_nxt = move_dir;
          if (at_goal) begin
            found_nxt = 1'b1;
          end else if (step_inc >= limit_r) begin
            found_nxt = 1'b0;
            if (!rule_r) begin
              // second attempt with the right-hand rule
              row_nxt  = CW'(1);
              col_nxt  = CW'(1);
              head_nxt = HEAD_POS_ROW;
              rule_nxt = 1'b1;
              step_nxt = '0;
            end
          end
        end else begin
          try_nxt = try_r + 2'd1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_found_nxt  = found_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      row_count_r  <= COUNT_RESET;
      col_count_r  <= COUNT_RESET;
      row_r        <= CW'(1);
      col_r        <= CW'(1);
      head_r       <= HEAD_POS_ROW;
      try_r        <= TRY_FIRST;
      rule_r       <= 1'b0;
      step_r       <= '0;
      limit_r      <= '0;
      found_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      head_r       <= head_nxt;
      try_r        <= try_nxt;
      rule_r       <= rule_nxt;
      step_r       <= step_nxt;
      limit_r      <= limit_nxt;
      found_r      <= found_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROW_COUNT: row_count_r <= cfg_wdata;
          CFG_COL_COUNT: col_count_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    inb_r       <= probe_inb;
    out_found_r <= out_found_nxt;
  end

  a_try_range: assert property (@(posedge clk) disable iff (!rst_n)
    try_r != 2'd3)
    else $error("neighbor try index out of range");

  a_step_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) |-> (step_r < limit_r))
    else $error("walk step past its limit");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result item without a finished walk");

  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> ((row_r <= CW'(MAX_DIM)) && (col_r <= CW'(MAX_DIM))))
    else $error("walker left the grid margin");

  a_busy_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_IDLE))
    else $error("grid write during a walk");

endmodule

// ===== tb/maze_walk_checker.sv =====
// checker for the maze walk: mirrors grid loads and size writes, predicts each walk result
module maze_walk_checker
  import wfmw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // cell_row[7:0], cell_col[15:8], cell_open[16], zero pad
  input  logic        in_tuser,   // command
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // path_found[0], zero pad
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  output int          results_due,
  output int          mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM = DEFAULT_MAX_DIM;

  typedef struct packed {
    logic [6:0] pad;
    logic       open;
    logic [7:0] col;
    logic [7:0] row;
  } cell_load_t;

  bit               grid [0:DIM*DIM-1];
  logic [CNT_W-1:0] row_count;
  logic [CNT_W-1:0] col_count;
  bit               found_q [$];
  int               bad;

  function automatic bit cell_open_at(int r, int c);
    if (r < 1 || c < 1 || r > DIM || c > DIM) return 1'b0;
    if (r > int'(row_count) || c > int'(col_count)) return 1'b0;
    return grid[(r - 1) * DIM + (c - 1)];
  endfunction

  function automatic int row_after(int r, heading_t h);
    case (h)
      HEAD_POS_ROW: return r + 1;
      HEAD_NEG_ROW: return r - 1;
      default:      return r;
    endcase
  endfunction

  function automatic int col_after(int c, heading_t h);
    case (h)
      HEAD_POS_COL: return c + 1;
      HEAD_NEG_COL: return c - 1;
      default:      return c;
    endcase
  endfunction

  function automatic bit clear_toward(int r, int c, heading_t h);
    return cell_open_at(row_after(r, h), col_after(c, h));
  endfunction

  // left-hand attempt, then right-hand attempt, each bounded by 2*rows*cols steps
  function automatic bit goal_reachable();
    int       r;
    int       c;
    int       lim;
    heading_t hd;
    heading_t side_a;
    heading_t side_b;
    heading_t ha;
    heading_t hb;
    if (!cell_open_at(1, 1)) return 1'b0;
    lim = 2 * int'(row_count) * int'(col_count);
    for (int rule = 0; rule < 2; rule++) begin
      side_a = (rule == 0) ? TURN_LEFT : TURN_RIGHT;
      side_b = (rule == 0) ? TURN_RIGHT : TURN_LEFT;
      r = 1;
      c = 1;
      hd = HEAD_POS_ROW;
      for (int steps = 0; steps < lim; steps++) begin
        ha = hd + side_a;
        hb = hd + side_b;
        if (clear_toward(r, c, ha)) begin
          hd = ha;
        end else if (!clear_toward(r, c, hd)) begin
          if (clear_toward(r, c, hb)) hd = hb;
          else hd = hd + TURN_AROUND;
        end
        r = row_after(r, hd);
        c = col_after(c, hd);
        if (r == int'(row_count) && c == int'(col_count)) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    cell_load_t ld;
    bit         want;
    if (!rst_n) begin
      row_count = COUNT_RESET;
      col_count = COUNT_RESET;
      found_q.delete();
      bad = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ROW_COUNT) row_count = cfg_wdata;
        else col_count = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == CMD_START) begin
          found_q.push_back(goal_reachable());
        end else begin
          ld = cell_load_t'(in_tdata);
          if (ld.row >= 1 && ld.col >= 1 && ld.row <= DIM && ld.col <= DIM)
            grid[(ld.row - 1) * DIM + (ld.col - 1)] = ld.open;
        end
      end
      if (out_tvalid && out_tready) begin
        if (found_q.size() == 0) begin
          bad++;
          if (bad <= 10) $display("unexpected result item: out_tdata %h", out_tdata);
        end else begin
          want = found_q.pop_front();
          if (out_tdata !== {7'd0, want}) begin
            bad++;
            if (bad <= 10)
              $display("path_found mismatch: expected %h, got %h", {7'd0, want}, out_tdata);
          end
        end
      end
    end
    results_due <= found_q.size();
    mismatches  <= bad;
  end

endmodule

// ===== tb/tb.sv =====
// testbench top for the maze walk: stimulus, idling and final verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wfmw_pkg::*;

  localparam int DIM       = DEFAULT_MAX_DIM;
  localparam int ITEM_GOAL = 1050;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // cell_row[7:0], cell_col[15:8], cell_open[16], zero pad
  logic        in_tuser;   // command
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // path_found[0], zero pad
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_wdata;
  int          results_due;
  int          mismatches;
  bit          calm;
  int          items_sent;

  wall_follower_maze_walk dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  maze_walk_checker walk_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .results_due (results_due),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      out_tready <= calm || ($urandom_range(99) >= 17);
    end
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic push_item(input logic cmd, input logic [23:0] data);
    if (!calm && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 17);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic load_cell(input int r, input int c, input bit open);
    if (r >= 1 && c >= 1 && r <= DIM && c <= DIM) items_sent++;
    push_item(CMD_LOAD, {7'd0, open, 8'(c), 8'(r)});
  endtask

  task automatic start_walk();
    items_sent++;
    push_item(CMD_START, {7'd0, 17'($urandom)});
  endtask

  // drain all results, then let in-flight loads settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_size(input int nr, input int nc);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROW_COUNT;
    cfg_wdata <= 8'(nr);
    @(posedge clk);
    cfg_index <= CFG_COL_COUNT;
    cfg_wdata <= 8'(nc);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic fill_grid(input int nr, input int nc, input int pct);
    for (int r = 1; r <= nr && r <= DIM; r++)
      for (int c = 1; c <= nc && c <= DIM; c++)
        load_cell(r, c, (r == 1 && c == 1) ? ($urandom_range(99) < 92)
                                           : ($urandom_range(99) < pct));
  endtask

  task automatic poke_cell(input int nr, input int nc);
    int pick;
    int hr;
    int hc;
    pick = $urandom_range(9);
    hr = (nr > DIM) ? DIM : nr;
    hc = (nc > DIM) ? DIM : nc;
    if (pick < 8)
      load_cell($urandom_range(1, hr), $urandom_range(1, hc), $urandom_range(99) < 70);
    else if (pick == 8)
      load_cell($urandom_range(1, DIM), $urandom_range(1, DIM), 1'($urandom_range(1)));
    else
      load_cell($urandom_range(255), $urandom_range(255), 1'($urandom_range(1)));
  endtask

  task automatic run_phase(input int nr, input int nc, input int pct, input int rounds);
    wait_idle();
    set_size(nr, nc);
    fill_grid(nr, nc, pct);
    repeat (rounds) begin
      repeat ($urandom_range(3)) poke_cell(nr, nc);
      start_walk();
    end
  endtask

  initial begin
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= CMD_LOAD;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_ROW_COUNT;
    cfg_wdata  <= '0;
    rst_n      <= 1'b0;
    calm       = 1'b0;
    items_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single cell grid at reset size, open then closed start
    load_cell(1, 1, 1'b1);
    start_walk();
    load_cell(1, 1, 1'b0);
    start_walk();
    // out of range loads are dropped
    load_cell(0, 5, 1'b1);
    load_cell(200, 1, 1'b1);
    load_cell(1, 0, 1'b1);
    load_cell(3, 255, 1'b0);
    load_cell(DIM, DIM, 1'b1);
    load_cell(1, 1, 1'b1);
    start_walk();
    // empty rectangle
    wait_idle();
    set_size(0, 1);
    start_walk();
    run_phase(2, 3, 100, 1);

    for (int k = 0; items_sent < ITEM_GOAL; k++) begin
      calm = (k % 5 == 1);
      case (k)
        1:       run_phase(DIM, 1, 88, 2);
        4:       run_phase(1, DIM, 88, 2);
        7:       run_phase(255, 1, 88, 2);
        default: run_phase($urandom_range(1, 10), $urandom_range(1, 10), 65,
                           $urandom_range(2, 6));
      endcase
    end

    calm = 1'b0;
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && results_due == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
